// File: src/dtps_pkg.sv
// Shared types and constants for the slash-separated date text parser.
// Used by the front classifier, the item queue, the back accumulator and the top level.
package dtps_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DAY_W       = 7;
    localparam int unsigned MONTH_W     = 7;
    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] SLASH_CODE = 8'h2F;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

    localparam logic [DAY_W-1:0]   DAY_MAX   = 7'd31;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;

    localparam logic [1:0] DAY_DIGITS_MAX   = 2'd2;
    localparam logic [1:0] MONTH_DIGITS_MAX = 2'd2;
    localparam logic [2:0] YEAR_DIGITS_MAX  = 3'd4;

    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;
    localparam logic [1:0] FIELD_SKIP  = 2'd3;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd2049;

    localparam logic [CFG_INDEX_W-1:0] CFG_YEAR_MIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_YEAR_MAX = 2'd1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DIGIT = 2'd0;
    localparam t_kind KIND_SLASH = 2'd1;
    localparam t_kind KIND_OTHER = 2'd2;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_char_item;

    typedef struct packed {
        logic [DAY_W-1:0]   day_value;
        logic [MONTH_W-1:0] month_value;
        logic [YEAR_W-1:0]  year_value;
        logic               date_valid;
    } t_result;

endpackage

// File: src/dtps_front.sv
// Front stage: accepts characters, classifies them as digit, slash or other.
// Depends on dtps_pkg; feeds dtps_queue.
module dtps_front
    import dtps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last,
    output logic              o_item_valid,
    output t_char_item        o_item,
    input  logic              i_queue_full
);

    logic       r_valid;
    t_char_item r_item;
    t_char_item n_item;
    logic       w_push;
    logic       w_take;
    logic [CHAR_W-1:0] w_offset;

    assign w_push  = r_valid && !i_queue_full;
    assign o_ready = !r_valid || w_push;
    assign w_take  = i_valid && o_ready;

    assign w_offset = i_char_code - DIGIT_ZERO;

    always_comb begin
        n_item.last  = i_last;
        n_item.digit = w_offset[DIGIT_W-1:0];
        if (i_char_code == SLASH_CODE) begin
            n_item.kind = KIND_SLASH;
        end else if (i_char_code >= DIGIT_ZERO && i_char_code <= DIGIT_NINE) begin
            n_item.kind = KIND_DIGIT;
        end else begin
            n_item.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// File: src/dtps_queue.sv
// Short queue of classified items between the front and back stages.
// Depends on dtps_pkg for the item type.
module dtps_queue
    import dtps_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_char_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_char_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_char_item       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// File: src/dtps_back.sv
// Back stage: accumulates day, month and year fields and emits one result per string.
// Depends on dtps_pkg; drains dtps_queue and owns the output register.
module dtps_back
    import dtps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  t_char_item        i_item,
    output logic              o_item_pop,
    input  logic [YEAR_W-1:0] i_year_min,
    input  logic [YEAR_W-1:0] i_year_max,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_result
);

    logic [1:0]         r_field_index, n_field_index;
    logic [DAY_W-1:0]   r_day_acc,     n_day_acc;
    logic [MONTH_W-1:0] r_month_acc,   n_month_acc;
    logic [YEAR_W-1:0]  r_year_acc,    n_year_acc;
    logic [1:0]         r_day_digits,  n_day_digits;
    logic [1:0]         r_month_digits, n_month_digits;
    logic [2:0]         r_year_digits, n_year_digits;
    logic               r_syntax_error, n_syntax_error;
    logic               r_out_valid;
    t_result            r_result;
    t_result            w_result;
    logic               w_out_free;
    logic               w_take;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = i_item_valid && (!i_item.last || w_out_free);
    assign o_item_pop = w_take;

    always_comb begin
        n_field_index  = r_field_index;
        n_day_acc      = r_day_acc;
        n_month_acc    = r_month_acc;
        n_year_acc     = r_year_acc;
        n_day_digits   = r_day_digits;
        n_month_digits = r_month_digits;
        n_year_digits  = r_year_digits;
        n_syntax_error = r_syntax_error;
        if (!r_syntax_error) begin
            unique case (i_item.kind)
                KIND_SLASH: begin
                    if (r_field_index == FIELD_SKIP) begin
                        n_syntax_error = 1'b1;
                    end else begin
                        n_field_index = r_field_index + 1'b1;
                    end
                end
                KIND_DIGIT: begin
                    unique case (r_field_index)
                        FIELD_DAY: begin
                            if (r_day_digits >= DAY_DIGITS_MAX) begin
                                n_syntax_error = 1'b1;
                            end else begin
                                n_day_acc = DAY_W'(r_day_acc * DAY_W'(10)
                                                   + DAY_W'(i_item.digit));
                                n_day_digits = r_day_digits + 1'b1;
                            end
                        end
                        FIELD_MONTH: begin
                            if (r_month_digits >= MONTH_DIGITS_MAX) begin
                                n_syntax_error = 1'b1;
                            end else begin
                                n_month_acc = MONTH_W'(r_month_acc * MONTH_W'(10)
                                                       + MONTH_W'(i_item.digit));
                                n_month_digits = r_month_digits + 1'b1;
                            end
                        end
                        FIELD_YEAR: begin
                            if (r_year_digits >= YEAR_DIGITS_MAX) begin
                                n_syntax_error = 1'b1;
                            end else begin
                                n_year_acc = YEAR_W'(r_year_acc * YEAR_W'(10)
                                                     + YEAR_W'(i_item.digit));
                                n_year_digits = r_year_digits + 1'b1;
                            end
                        end
                        default: begin
                            // past the third slash: drop digits
                        end
                    endcase
                end
                default: begin
                    n_syntax_error = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        w_result.day_value   = n_day_acc;
        w_result.month_value = n_month_acc;
        w_result.year_value  = n_year_acc;
        w_result.date_valid  = !n_syntax_error
                               && (n_day_acc != '0) && (n_day_acc <= DAY_MAX)
                               && (n_month_acc != '0) && (n_month_acc <= MONTH_MAX)
                               && (n_year_acc >= i_year_min)
                               && (n_year_acc <= i_year_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_index  <= '0;
            r_day_acc      <= '0;
            r_month_acc    <= '0;
            r_year_acc     <= '0;
            r_day_digits   <= '0;
            r_month_digits <= '0;
            r_year_digits  <= '0;
            r_syntax_error <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_take && i_item.last) begin
                // string done: clear the parse for the next one
                r_field_index  <= '0;
                r_day_acc      <= '0;
                r_month_acc    <= '0;
                r_year_acc     <= '0;
                r_day_digits   <= '0;
                r_month_digits <= '0;
                r_year_digits  <= '0;
                r_syntax_error <= 1'b0;
                r_out_valid    <= 1'b1;
            end else begin
                if (w_take) begin
                    r_field_index  <= n_field_index;
                    r_day_acc      <= n_day_acc;
                    r_month_acc    <= n_month_acc;
                    r_year_acc     <= n_year_acc;
                    r_day_digits   <= n_day_digits;
                    r_month_digits <= n_month_digits;
                    r_year_digits  <= n_year_digits;
                    r_syntax_error <= n_syntax_error;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.last) |=> (r_field_index == '0 && !r_syntax_error
                                     && r_year_digits == '0))
        else $error("parse state not cleared after last item");

    a_year_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_year_digits <= YEAR_DIGITS_MAX)
        else $error("year digit count out of range");

    a_day_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day_digits <= DAY_DIGITS_MAX) && (r_month_digits <= MONTH_DIGITS_MAX))
        else $error("day or month digit count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("pending result lost");

endmodule

// File: src/date_text_parse_slash_top.sv
// Day/month/year date text parser, one character per item, one result per string.
// A result passes the front register, the queue and the back stage's output register.
// Throughput: one character per cycle while no result waits; the back stage takes one
// queued item per cycle. While a result waits, it holds at the next last character; the
// queue and front register take two more items behind it before s_axis_tready drops.
// Reset (i_rst_n low, synchronous) clears the parse state, queue and output valid, and
// loads year bounds 1900..2049.
module date_text_parse_slash_top
    import dtps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [6:0] day_value, [13:7] month_value,
                                                   // [27:14] year_value, [31:28] zero
    output logic                   m_axis_tuser,   // [0] date_valid
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [YEAR_W-1:0]      i_cfg_data
);

    logic [YEAR_W-1:0] r_year_min_val;
    logic [YEAR_W-1:0] r_year_max_val;
    logic              w_front_valid;
    t_char_item        w_front_item;
    logic              w_queue_full;
    logic              w_queue_valid;
    t_char_item        w_queue_item;
    logic              w_pop;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min_val <= YEAR_MIN_RESET;
            r_year_max_val <= YEAR_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_YEAR_MIN: begin
                    r_year_min_val <= i_cfg_data;
                end
                CFG_YEAR_MAX: begin
                    r_year_max_val <= i_cfg_data;
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    dtps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_char_code  (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_item_valid (w_front_valid),
        .o_item       (w_front_item),
        .i_queue_full (w_queue_full)
    );

    dtps_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_item),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    dtps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_queue_valid),
        .i_item       (w_queue_item),
        .o_item_pop   (w_pop),
        .i_year_min   (r_year_min_val),
        .i_year_max   (r_year_max_val),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_result     (w_result)
    );

    assign m_axis_tdata = {4'b0000, w_result.year_value, w_result.month_value,
                           w_result.day_value};
    assign m_axis_tuser = w_result.date_valid;

endmodule
